/* design/power_training_load_metrics_top_macros.svh */
`ifndef POWER_TRAINING_LOAD_METRICS_TOP_MACROS_SVH
`define POWER_TRAINING_LOAD_METRICS_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define PTLM_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and held off during reset.
`define PTLM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/ptlm_pkg.sv */
`default_nettype none

package ptlm_pkg;

    localparam int PWR_W  = 12;
    localparam int SECS_W = 20;
    localparam int THR_W  = 11;
    localparam int Q20_W  = 20;
    localparam int CNT_W  = 20;
    localparam int SUM_W  = 32;
    localparam int LAP_W  = 16;
    localparam int BB_W   = 16;

    localparam logic FUNC_SAMPLE = 1'b0;
    localparam logic FUNC_LAP    = 1'b1;

    localparam logic [THR_W-1:0] THR_RESET = 11'd200;
    localparam logic [CNT_W-1:0] CNT_MAX   = 20'hFFFFF;
    localparam logic [Q20_W-1:0] Q20_MAX   = 20'hFFFFF;
    localparam logic [BB_W-1:0]  BB_MAX    = 16'hFFFF;

    localparam logic [63:0] ENERGY_BIAS = 64'd500;
    localparam logic [39:0] ENERGY_DIV  = 40'd1000;
    localparam logic [63:0] TSS_BIAS    = 64'd1179648;
    localparam logic [39:0] TSS_DIV     = 40'd36;
    localparam logic [47:0] A_MAX       = 48'hFFFF_FFFF_FFFF;

    localparam logic [1:0] OP_DIV  = 2'd0;
    localparam logic [1:0] OP_MUL  = 2'd1;
    localparam logic [1:0] OP_SQRT = 2'd2;

    typedef struct packed {
        logic              func;
        logic [PWR_W-1:0]  power_watts;
        logic [SECS_W-1:0] elapsed_seconds;
        logic              workout_over;
    } in_item_t;

    typedef struct packed {
        logic [Q20_W-1:0] avg_workout_power;
        logic [Q20_W-1:0] avg_interval_power;
        logic [31:0]      energy_kj;
        logic [Q20_W-1:0] normalized_power;
        logic [Q20_W-1:0] intensity_factor;
        logic [31:0]      training_stress;
        logic [LAP_W-1:0] lap_count;
    } out_item_t;

endpackage

`default_nettype wire

/* design/ptlm_in_if.sv */
`default_nettype none

interface ptlm_in_if;
    logic               valid;
    logic               ready;
    ptlm_pkg::in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* design/ptlm_out_if.sv */
`default_nettype none

interface ptlm_out_if;
    logic                valid;
    logic                ready;
    ptlm_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* design/power_training_load_metrics_top.sv */
// Each accepted power sample or interval end event yields one result word,
// and one word is in flight at a time.
// The work is done by one shared bit-serial unit: a divider (64 steps), a shift-add
// multiplier (32 steps) and a square root (32 steps), used in turn.
// Reset (rst_n low, asynchronous) clears all sums, counts and last metrics and sets
// the threshold to 200 W; the block is ready for a word in the first cycle after it.
`default_nettype none

`include "power_training_load_metrics_top_macros.svh"

module power_training_load_metrics_top #(
    parameter int BLOCK_LEN = 30
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    ptlm_in_if.sink                         in_ch,
    ptlm_out_if.source                      out_ch,
    input  wire logic                       cfg_wr_en,
    input  wire logic [ptlm_pkg::THR_W-1:0] cfg_wr_data
);
    import ptlm_pkg::*;

    localparam int PosW  = $clog2(BLOCK_LEN + 1);
    localparam int BsumW = PWR_W + PosW;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_WMEAN  = 4'd1;
    localparam logic [3:0] ST_IMEAN  = 4'd2;
    localparam logic [3:0] ST_ENERGY = 4'd3;
    localparam logic [3:0] ST_BMEAN  = 4'd4;
    localparam logic [3:0] ST_MSQ    = 4'd5;
    localparam logic [3:0] ST_FSQ    = 4'd6;
    localparam logic [3:0] ST_AVG    = 4'd7;
    localparam logic [3:0] ST_SQ1    = 4'd8;
    localparam logic [3:0] ST_SQ2    = 4'd9;
    localparam logic [3:0] ST_IF     = 4'd10;
    localparam logic [3:0] ST_ISQ    = 4'd11;
    localparam logic [3:0] ST_ISEC   = 4'd12;
    localparam logic [3:0] ST_TSS    = 4'd13;
    localparam logic [3:0] ST_FINISH = 4'd14;

    localparam logic [1:0] PH_LOAD  = 2'd0;
    localparam logic [1:0] PH_RUN   = 2'd1;
    localparam logic [1:0] PH_STORE = 2'd2;

    logic [3:0]       state_reg, state_next;
    logic [1:0]       phase_reg, phase_next;
    logic [1:0]       op_reg, op_next;
    logic [5:0]       cnt_reg, cnt_next;
    logic [63:0]      x_reg, x_next;
    logic [33:0]      rem_reg, rem_next;
    logic [63:0]      q_reg, q_next;
    logic [39:0]      d_reg, d_next;
    logic [63:0]      tmp_reg, tmp_next;
    logic [47:0]      f_reg, f_next;

    logic [THR_W-1:0] thr_reg, thr_next;
    logic [CNT_W-1:0] wc_reg, wc_next;
    logic [SUM_W-1:0] ws_reg, ws_next;
    logic [CNT_W-1:0] ic_reg, ic_next;
    logic [SUM_W-1:0] is_reg, is_next;
    logic [PosW-1:0]  bp_reg, bp_next;
    logic [PosW-1:0]  n_reg, n_next;
    logic [BsumW-1:0] bs_reg, bs_next;
    logic [BB_W-1:0]  bb_reg, bb_next;
    logic [63:0]      fpt_reg, fpt_next;
    logic [LAP_W-1:0] laps_reg, laps_next;
    logic             blk_done_reg, blk_done_next;
    logic             func_reg, func_next;
    logic [SECS_W-1:0] secs_reg, secs_next;

    logic [Q20_W-1:0] wmean_reg, wmean_next;
    logic [Q20_W-1:0] imean_reg, imean_next;
    logic [31:0]      energy_reg, energy_next;
    logic [Q20_W-1:0] np_reg, np_next;
    logic [Q20_W-1:0] iff_reg, iff_next;
    logic [31:0]      tss_reg, tss_next;

    logic             out_valid_reg, out_valid_next;
    out_item_t        out_reg, out_next;

    logic [34:0]      trial_a;
    logic [34:0]      trial_b;
    logic [35:0]      diff;
    logic             ge;
    logic [63:0]      mul_sum;
    logic [64:0]      fsum;
    logic [63:0]      a_in;
    logic [THR_W-1:0] thr_eff;
    logic [PosW-1:0]  n_new;

    assign in_ch.ready  = (state_reg == ST_IDLE);
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_reg;

    // One shared subtractor serves the restoring divider and the square root.
    assign trial_a = (op_reg == OP_DIV) ? {1'b0, rem_reg[32:0], x_reg[63]}
                                        : {rem_reg[32:0], x_reg[63:62]};
    assign trial_b = (op_reg == OP_DIV) ? {15'd0, d_reg[19:0]}
                                        : {q_reg[32:0], 2'b01};
    assign diff    = {1'b0, trial_a} - {1'b0, trial_b};
    assign ge      = !diff[35];
    assign mul_sum = {q_reg[62:0], 1'b0} + (x_reg[63] ? {24'd0, d_reg} : 64'd0);

    assign fsum    = {1'b0, fpt_reg} + {17'd0, f_reg};
    assign a_in    = fsum[64] ? {64{1'b1}} : fsum[63:0];
    assign thr_eff = (thr_reg == '0) ? THR_W'(1) : thr_reg;
    assign n_new   = bp_reg + PosW'(1);

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        op_next        = op_reg;
        cnt_next       = cnt_reg;
        x_next         = x_reg;
        rem_next       = rem_reg;
        q_next         = q_reg;
        d_next         = d_reg;
        tmp_next       = tmp_reg;
        f_next         = f_reg;
        thr_next       = thr_reg;
        wc_next        = wc_reg;
        ws_next        = ws_reg;
        ic_next        = ic_reg;
        is_next        = is_reg;
        bp_next        = bp_reg;
        n_next         = n_reg;
        bs_next        = bs_reg;
        bb_next        = bb_reg;
        fpt_next       = fpt_reg;
        laps_next      = laps_reg;
        blk_done_next  = blk_done_reg;
        func_next      = func_reg;
        secs_next      = secs_reg;
        wmean_next     = wmean_reg;
        imean_next     = imean_reg;
        energy_next    = energy_reg;
        np_next        = np_reg;
        iff_next       = iff_reg;
        tss_next       = tss_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        out_next       = out_reg;

        if (cfg_wr_en)
        begin
            thr_next = cfg_wr_data;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid)
                begin
                    func_next  = in_ch.data.func;
                    secs_next  = in_ch.data.elapsed_seconds;
                    state_next = ST_WMEAN;
                    phase_next = PH_LOAD;
                    if (in_ch.data.func == FUNC_SAMPLE)
                    begin
                        if (wc_reg < CNT_MAX)
                        begin
                            wc_next = wc_reg + CNT_W'(1);
                            ws_next = ws_reg + SUM_W'(in_ch.data.power_watts);
                        end
                        if (ic_reg < CNT_MAX)
                        begin
                            ic_next = ic_reg + CNT_W'(1);
                            is_next = is_reg + SUM_W'(in_ch.data.power_watts);
                        end
                        if (bp_reg == '0)
                        begin
                            bs_next = BsumW'(in_ch.data.power_watts);
                            if (bb_reg < BB_MAX)
                            begin
                                bb_next = bb_reg + BB_W'(1);
                            end
                        end
                        else
                        begin
                            bs_next = bs_reg + BsumW'(in_ch.data.power_watts);
                        end
                        n_next        = n_new;
                        blk_done_next = (32'(n_new) >= BLOCK_LEN);
                        bp_next       = (32'(n_new) >= BLOCK_LEN) ? '0 : n_new;
                    end
                    else
                    begin
                        if (!in_ch.data.workout_over)
                        begin
                            ic_next = '0;
                            is_next = '0;
                        end
                        laps_next = laps_reg + LAP_W'(1);
                    end
                end
            end

            ST_FINISH:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_next.avg_workout_power  = wmean_reg;
                    out_next.avg_interval_power = imean_reg;
                    out_next.energy_kj          = energy_reg;
                    out_next.normalized_power   = np_reg;
                    out_next.intensity_factor   = iff_reg;
                    out_next.training_stress    = tss_reg;
                    out_next.lap_count          = laps_reg;
                    out_valid_next              = 1'b1;
                    state_next                  = ST_IDLE;
                end
            end

            default:
            begin
                case (phase_reg)
                    PH_LOAD:
                    begin
                        rem_next   = '0;
                        q_next     = '0;
                        op_next    = OP_DIV;
                        cnt_next   = 6'd63;
                        phase_next = PH_RUN;
                        case (state_reg)
                            ST_WMEAN:
                            begin
                                x_next = {24'd0, ws_reg, 8'd0} + {45'd0, wc_reg[19:1]};
                                d_next = {20'd0, wc_reg};
                            end
                            ST_IMEAN:
                            begin
                                x_next = {24'd0, is_reg, 8'd0} + {45'd0, ic_reg[19:1]};
                                d_next = {20'd0, ic_reg};
                            end
                            ST_ENERGY:
                            begin
                                x_next = {24'd0, ws_reg, 8'd0} + ENERGY_BIAS;
                                d_next = ENERGY_DIV;
                            end
                            ST_BMEAN:
                            begin
                                x_next = (64'(bs_reg) << 8) + 64'(n_reg >> 1);
                                d_next = 40'(n_reg);
                            end
                            ST_MSQ:
                            begin
                                op_next  = OP_MUL;
                                cnt_next = 6'd31;
                                x_next   = {tmp_reg[31:0], 32'd0};
                                d_next   = tmp_reg[39:0];
                            end
                            ST_FSQ:
                            begin
                                op_next  = OP_MUL;
                                cnt_next = 6'd31;
                                x_next   = {tmp_reg[31:0], 32'd0};
                                d_next   = {8'd0, tmp_reg[31:0]};
                            end
                            ST_AVG:
                            begin
                                x_next = a_in;
                                d_next = {24'd0, bb_reg};
                                // A finished block keeps its fourth power for later means.
                                if (blk_done_reg)
                                begin
                                    fpt_next = a_in;
                                end
                            end
                            ST_SQ1:
                            begin
                                op_next  = OP_SQRT;
                                cnt_next = 6'd31;
                                x_next   = {tmp_reg[47:0], 16'd0};
                            end
                            ST_SQ2:
                            begin
                                op_next  = OP_SQRT;
                                cnt_next = 6'd31;
                                x_next   = {24'd0, tmp_reg[31:0], 8'd0};
                            end
                            ST_IF:
                            begin
                                x_next = 64'({np_reg, 4'd0}) + 64'(thr_eff >> 1);
                                d_next = 40'(thr_eff);
                            end
                            ST_ISQ:
                            begin
                                op_next  = OP_MUL;
                                cnt_next = 6'd31;
                                x_next   = {12'd0, iff_reg, 32'd0};
                                d_next   = {20'd0, iff_reg};
                            end
                            ST_ISEC:
                            begin
                                op_next  = OP_MUL;
                                cnt_next = 6'd31;
                                x_next   = {12'd0, secs_reg, 32'd0};
                                d_next   = tmp_reg[39:0];
                            end
                            ST_TSS:
                            begin
                                x_next = (tmp_reg + TSS_BIAS) >> 16;
                                d_next = TSS_DIV;
                            end
                            default:
                            begin
                                x_next = '0;
                            end
                        endcase
                    end

                    PH_RUN:
                    begin
                        case (op_reg)
                            OP_DIV:
                            begin
                                rem_next = ge ? diff[33:0] : {1'b0, trial_a[32:0]};
                                q_next   = {q_reg[62:0], ge};
                                x_next   = {x_reg[62:0], 1'b0};
                            end
                            OP_MUL:
                            begin
                                q_next = mul_sum;
                                x_next = {x_reg[62:0], 1'b0};
                            end
                            OP_SQRT:
                            begin
                                rem_next = ge ? diff[33:0] : trial_a[33:0];
                                q_next   = {q_reg[62:0], ge};
                                x_next   = {x_reg[61:0], 2'b00};
                            end
                            default:
                            begin
                                q_next = q_reg;
                            end
                        endcase
                        cnt_next = cnt_reg - 6'd1;
                        if (cnt_reg == '0)
                        begin
                            phase_next = PH_STORE;
                        end
                    end

                    PH_STORE:
                    begin
                        phase_next = PH_LOAD;
                        case (state_reg)
                            ST_WMEAN:
                            begin
                                wmean_next = (wc_reg == '0) ? '0 : q_reg[19:0];
                                state_next = ST_IMEAN;
                            end
                            ST_IMEAN:
                            begin
                                imean_next = (ic_reg == '0) ? '0 : q_reg[19:0];
                                state_next = ST_ENERGY;
                            end
                            ST_ENERGY:
                            begin
                                energy_next = q_reg[31:0];
                                state_next  = (func_reg == FUNC_LAP) ? ST_FINISH : ST_BMEAN;
                            end
                            ST_BMEAN:
                            begin
                                tmp_next   = {44'd0, q_reg[19:0]};
                                state_next = ST_MSQ;
                            end
                            ST_MSQ:
                            begin
                                tmp_next   = {32'd0, q_reg[39:8]};
                                state_next = ST_FSQ;
                            end
                            ST_FSQ:
                            begin
                                f_next     = q_reg[63:16];
                                state_next = ST_AVG;
                            end
                            ST_AVG:
                            begin
                                tmp_next   = (q_reg[63:48] != '0) ? {16'd0, A_MAX}
                                                                  : {16'd0, q_reg[47:0]};
                                state_next = ST_SQ1;
                            end
                            ST_SQ1:
                            begin
                                tmp_next   = {32'd0, q_reg[31:0]};
                                state_next = ST_SQ2;
                            end
                            ST_SQ2:
                            begin
                                np_next    = q_reg[19:0];
                                state_next = ST_IF;
                            end
                            ST_IF:
                            begin
                                iff_next   = (q_reg[63:20] != '0) ? Q20_MAX : q_reg[19:0];
                                state_next = ST_ISQ;
                            end
                            ST_ISQ:
                            begin
                                tmp_next   = {24'd0, q_reg[39:0]};
                                state_next = ST_ISEC;
                            end
                            ST_ISEC:
                            begin
                                tmp_next   = q_reg;
                                state_next = ST_TSS;
                            end
                            ST_TSS:
                            begin
                                tss_next   = (q_reg[63:32] != '0) ? 32'hFFFF_FFFF : q_reg[31:0];
                                state_next = ST_FINISH;
                            end
                            default:
                            begin
                                state_next = ST_IDLE;
                            end
                        endcase
                    end

                    default:
                    begin
                        phase_next = PH_LOAD;
                    end
                endcase
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_LOAD;
            op_reg        <= OP_DIV;
            cnt_reg       <= '0;
            x_reg         <= '0;
            rem_reg       <= '0;
            q_reg         <= '0;
            d_reg         <= '0;
            tmp_reg       <= '0;
            f_reg         <= '0;
            thr_reg       <= THR_RESET;
            wc_reg        <= '0;
            ws_reg        <= '0;
            ic_reg        <= '0;
            is_reg        <= '0;
            bp_reg        <= '0;
            n_reg         <= '0;
            bs_reg        <= '0;
            bb_reg        <= '0;
            fpt_reg       <= '0;
            laps_reg      <= '0;
            blk_done_reg  <= 1'b0;
            func_reg      <= FUNC_SAMPLE;
            secs_reg      <= '0;
            wmean_reg     <= '0;
            imean_reg     <= '0;
            energy_reg    <= '0;
            np_reg        <= '0;
            iff_reg       <= '0;
            tss_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            op_reg        <= op_next;
            cnt_reg       <= cnt_next;
            x_reg         <= x_next;
            rem_reg       <= rem_next;
            q_reg         <= q_next;
            d_reg         <= d_next;
            tmp_reg       <= tmp_next;
            f_reg         <= f_next;
            thr_reg       <= thr_next;
            wc_reg        <= wc_next;
            ws_reg        <= ws_next;
            ic_reg        <= ic_next;
            is_reg        <= is_next;
            bp_reg        <= bp_next;
            n_reg         <= n_next;
            bs_reg        <= bs_next;
            bb_reg        <= bb_next;
            fpt_reg       <= fpt_next;
            laps_reg      <= laps_next;
            blk_done_reg  <= blk_done_next;
            func_reg      <= func_next;
            secs_reg      <= secs_next;
            wmean_reg     <= wmean_next;
            imean_reg     <= imean_next;
            energy_reg    <= energy_next;
            np_reg        <= np_next;
            iff_reg       <= iff_next;
            tss_reg       <= tss_next;
            out_valid_reg <= out_valid_next;
            out_reg       <= out_next;
        end
    end

    `PTLM_ASSERT_NEXT(a_accept_starts, in_ch.valid && in_ch.ready, state_reg == ST_WMEAN, "accepted word did not start the sequence")
    `PTLM_ASSERT_NEXT(a_run_ends, phase_reg == PH_RUN && cnt_reg == '0 && state_reg != ST_IDLE && state_reg != ST_FINISH, phase_reg == PH_STORE, "serial unit did not hand over its result")
    `PTLM_ASSERT_IMPL(a_out_from_finish, $rose(out_valid_reg), $past(state_reg) == ST_FINISH, "result word raised outside the finish step")
    `PTLM_ASSERT_NEXT(a_blocks_counted, in_ch.valid && in_ch.ready && in_ch.data.func == FUNC_SAMPLE, bb_reg != '0, "sample left no block begun")

endmodule

`default_nettype wire

/* tb/power_training_load_metrics_top_test.sv */
`timescale 1ns / 100ps
`default_nettype none

module power_training_load_metrics_top_test;
    import ptlm_pkg::*;

    localparam int BLOCK_LEN   = 30;
    localparam int CYCLE_LIMIT = 8000000;
    localparam int MAX_SHOWN   = 10;

    typedef struct {
        bit               is_cfg;
        bit               quiet;
        logic [THR_W-1:0] thr;
        in_item_t         word;
    } pending_t;

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [THR_W-1:0] cfg_wr_data;

    ptlm_in_if  in_ch ();
    ptlm_out_if out_ch ();

    power_training_load_metrics_top #(
        .BLOCK_LEN(BLOCK_LEN)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    pending_t  pending_words[$];
    out_item_t expected_metrics[$];
    int        mismatches;
    bit        quiet_phase;
    bit        stim_done;
    int        send_gap;
    int        recv_stall;
    longint    cycles;

    // Predictor state, mirroring the block's registers.
    logic [THR_W-1:0] thr_model = THR_RESET;
    logic [31:0] wk_count = '0, wk_sum = '0, iv_count = '0, iv_sum = '0;
    logic [4:0]  blk_pos = '0;
    logic [16:0] blk_sum = '0;
    logic [15:0] blk_begun = '0;
    logic [63:0] fourth_total = '0;
    logic [15:0] lap_model = '0;
    logic [19:0] last_np = '0, last_if = '0;
    logic [31:0] last_tss = '0;

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic logic [63:0] floor_sqrt(logic [63:0] x);
        logic [63:0] root;
        logic [63:0] trial;
        root = 0;
        for (int b = 31; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= x)
                root = trial;
        end
        return root;
    endfunction

    function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        return (s < a) ? 64'hFFFF_FFFF_FFFF_FFFF : s;
    endfunction

    function automatic logic [19:0] mean_q8(logic [31:0] sum, logic [31:0] cnt);
        logic [63:0] q;
        if (cnt == 0)
            return 20'd0;
        q = ({32'd0, sum} * 256 + cnt / 2) / cnt;
        return q[19:0];
    endfunction

    function automatic out_item_t compute_metrics(in_item_t w);
        out_item_t   r;
        logic [63:0] n, m, s, f, a, np, ifq, tss, thr, e;
        if (w.func == FUNC_SAMPLE)
        begin
            if (wk_count < CNT_MAX)
            begin
                wk_count = wk_count + 32'd1;
                wk_sum   = wk_sum + 32'(w.power_watts);
            end
            if (iv_count < CNT_MAX)
            begin
                iv_count = iv_count + 32'd1;
                iv_sum   = iv_sum + 32'(w.power_watts);
            end
            if (blk_pos == 0)
            begin
                blk_sum = 17'(w.power_watts);
                if (blk_begun != 16'hFFFF)
                    blk_begun = blk_begun + 16'd1;
            end
            else
                blk_sum = blk_sum + 17'(w.power_watts);
            n = 64'(blk_pos) + 64'd1;
            m = ({47'd0, blk_sum} * 256 + n / 2) / n;
            s = (m * m) >> 8;
            f = (s * s) >> 16;
            a = add_sat(fourth_total, f);
            a = (blk_begun != 0) ? a / 64'(blk_begun) : 64'd0;
            if (a > A_MAX)
                a = A_MAX;
            np = floor_sqrt(floor_sqrt(a << 16) << 8);
            if (np > Q20_MAX)
                np = Q20_MAX;
            thr = (thr_model == 0) ? 64'd1 : 64'(thr_model);
            ifq = ((np << 4) + thr / 2) / thr;
            if (ifq > Q20_MAX)
                ifq = Q20_MAX;
            tss = (ifq * ifq * 64'(w.elapsed_seconds) + 64'd36 * 32768) / (64'd36 * 65536);
            if (tss > 64'hFFFF_FFFF)
                tss = 64'hFFFF_FFFF;
            last_np  = np[19:0];
            last_if  = ifq[19:0];
            last_tss = tss[31:0];
            if (n >= BLOCK_LEN)
            begin
                blk_pos      = 0;
                fourth_total = add_sat(fourth_total, f);
            end
            else
                blk_pos = n[4:0];
        end
        else
        begin
            if (!w.workout_over)
            begin
                iv_sum   = 0;
                iv_count = 0;
            end
            lap_model = lap_model + 16'd1;
        end
        e = ({32'd0, wk_sum} * 256 + 500) / 1000;
        r.avg_workout_power  = mean_q8(wk_sum, wk_count);
        r.avg_interval_power = mean_q8(iv_sum, iv_count);
        r.energy_kj          = (e > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : e[31:0];
        r.normalized_power   = last_np;
        r.intensity_factor   = last_if;
        r.training_stress    = last_tss;
        r.lap_count          = lap_model;
        return r;
    endfunction

    // Mostly short gaps, a few long ones; none during a quiet phase.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet_phase || roll < 40)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 20);
        return $urandom_range(50, 800);
    endfunction

    // Driver: one nonblocking assignment per signal per clock.
    always @(posedge clk or negedge rst_n)
    begin
        logic     nv;
        in_item_t nd;
        logic     nwe;
        logic [THR_W-1:0] nwd;
        bit       taken;
        pending_t head;
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.data  <= '0;
            cfg_wr_en   <= 1'b0;
            cfg_wr_data <= '0;
            send_gap    = 0;
            stim_done   = 0;
        end
        else
        begin
            taken = in_ch.valid && in_ch.ready;
            if (taken)
                expected_metrics.push_back(compute_metrics(in_ch.data));
            nv  = in_ch.valid && !taken;
            nd  = in_ch.data;
            nwe = 1'b0;
            nwd = cfg_wr_data;
            if (!nv)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (pending_words.size() > 0)
                begin
                    head = pending_words[0];
                    if (head.is_cfg)
                    begin
                        // Settings change only once the block has drained.
                        if (expected_metrics.size() == 0 && !taken)
                        begin
                            nwe         = 1'b1;
                            nwd         = head.thr;
                            thr_model   = head.thr;
                            quiet_phase = head.quiet;
                            void'(pending_words.pop_front());
                        end
                    end
                    else
                    begin
                        nv = 1'b1;
                        nd = head.word;
                        void'(pending_words.pop_front());
                        send_gap = pick_gap();
                    end
                end
                else
                    stim_done = 1;
            end
            in_ch.valid <= nv;
            in_ch.data  <= nd;
            cfg_wr_en   <= nwe;
            cfg_wr_data <= nwd;
        end
    end

    // Monitor: random back-pressure and in-order comparison.
    always @(posedge clk or negedge rst_n)
    begin
        out_item_t want;
        out_item_t got;
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            recv_stall   = 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                got = out_ch.data;
                if (expected_metrics.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("unexpected result word %p", got);
                end
                else
                begin
                    want = expected_metrics.pop_front();
                    if (got.avg_workout_power !== want.avg_workout_power
                        || got.avg_interval_power !== want.avg_interval_power
                        || got.energy_kj !== want.energy_kj
                        || got.normalized_power !== want.normalized_power
                        || got.intensity_factor !== want.intensity_factor
                        || got.training_stress !== want.training_stress
                        || got.lap_count !== want.lap_count)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_SHOWN)
                            $display("mismatch: expected %p actual %p", want, got);
                    end
                end
                recv_stall = pick_gap();
            end
            if (recv_stall > 0)
            begin
                recv_stall--;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    logic [19:0] secs_now;

    task automatic add_word(logic f, logic [PWR_W-1:0] p, logic [SECS_W-1:0] t, logic over);
        pending_t e;
        e.is_cfg = 0;
        e.quiet  = 0;
        e.thr    = '0;
        e.word.func            = f;
        e.word.power_watts     = p;
        e.word.elapsed_seconds = t;
        e.word.workout_over    = over;
        pending_words.push_back(e);
    endtask

    task automatic add_setting(logic [THR_W-1:0] t, bit q);
        pending_t e;
        e.is_cfg = 1;
        e.quiet  = q;
        e.thr    = t;
        e.word   = '0;
        pending_words.push_back(e);
    endtask

    task automatic add_random_phase(int count);
        int roll;
        logic [PWR_W-1:0] p;
        for (int i = 0; i < count; i++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 8)
                add_word(FUNC_LAP, PWR_W'($urandom), SECS_W'($urandom),
                         1'($urandom_range(0, 1)));
            else
            begin
                roll = $urandom_range(0, 99);
                if (roll < 60)
                    p = PWR_W'($urandom_range(80, 450));
                else if (roll < 85)
                    p = PWR_W'($urandom);
                else if (roll < 93)
                    p = '0;
                else
                    p = 12'hFFF;
                if ($urandom_range(0, 19) == 0)
                    secs_now = SECS_W'($urandom);
                else
                    secs_now = secs_now + 20'd1;
                add_word(FUNC_SAMPLE, p, secs_now, 1'($urandom_range(0, 1)));
            end
        end
    endtask

    initial
    begin
        logic [THR_W-1:0] thr_list[$];
        secs_now     = 0;

        // Directed words: empty means, lap events both ways, field extremes.
        add_word(FUNC_LAP, 12'hFFF, 20'hFFFFF, 1'b0);
        add_word(FUNC_LAP, 12'h000, 20'h00000, 1'b1);
        add_word(FUNC_SAMPLE, 12'h000, 20'h00000, 1'b0);
        add_word(FUNC_SAMPLE, 12'hFFF, 20'hFFFFF, 1'b1);
        add_word(FUNC_SAMPLE, 12'hFFF, 20'hFFFFF, 1'b0);
        add_word(FUNC_LAP, 12'hABC, 20'h12345, 1'b1);
        add_word(FUNC_SAMPLE, 12'd250, 20'd3, 1'b0);
        add_word(FUNC_LAP, 12'd0, 20'd0, 1'b0);
        add_word(FUNC_SAMPLE, 12'd300, 20'd4, 1'b1);
        add_word(FUNC_SAMPLE, 12'h555, 20'hAAAAA, 1'b0);
        add_word(FUNC_SAMPLE, 12'hAAA, 20'h55555, 1'b0);
        secs_now = 20'd10;

        thr_list = '{11'd1, 11'd2047, 11'd0, 11'd200, 11'd0, 11'd0, 11'd2047};
        thr_list[4] = THR_W'($urandom_range(1, 2047));
        thr_list[5] = THR_W'($urandom_range(100, 400));
        add_random_phase(200);
        foreach (thr_list[i])
        begin
            add_setting(thr_list[i], (i == 2));
            add_random_phase(200);
        end

        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (!(stim_done && expected_metrics.size() == 0 && !in_ch.valid))
            @(posedge clk);
        repeat (1000) @(posedge clk);
        if (mismatches == 0 && expected_metrics.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
+incdir+design
design/ptlm_pkg.sv
design/ptlm_in_if.sv
design/ptlm_out_if.sv
design/power_training_load_metrics_top.sv
tb/power_training_load_metrics_top_test.sv
